FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication with reset disable
`define AST_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication with reset disable
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/aest_pkg.sv
`timescale 1ns / 1ps
package aest_pkg;
   localparam int MAX_CHUNK_DEF = 1024;
   localparam logic [31:0] NOISE_RESET = 32'd400 << 16;
   // floor(2^42 / 1000); the estimate built on it falls short by at most two
   localparam logic [32:0] RECIP_1000 = 33'd4398046511;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_SENS   = 3'd1;
   localparam logic [2:0] REG_MINRMS = 3'd2;
   localparam logic [2:0] REG_HOLD   = 3'd3;
   localparam logic [2:0] REG_COOL   = 3'd4;

   typedef enum logic [2:0] {
      ST_ACC, ST_DIV, ST_SQRT, ST_EVAL, ST_MIX, ST_UPD, ST_OUT
   } state_type;

   typedef struct packed {
      logic acc_en;
      logic start_div;
      logic start_sqrt;
      logic eval;
      logic update;
      logic chunk_clear;
      logic busy_drop;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic mix_done;
   } status_type;

   function automatic logic [5:0] mult_tenths(input logic [2:0] lvl);
      case (lvl)
         3'd1: mult_tenths = 6'd20;
         3'd2: mult_tenths = 6'd26;
         3'd3: mult_tenths = 6'd32;
         3'd4: mult_tenths = 6'd40;
         default: mult_tenths = 6'd50;
      endcase
   endfunction
endpackage

FILE: src/aest_ctrl.sv
`timescale 1ns / 1ps
module aest_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                in_cmd,
   input  logic                in_last,
   input  logic                in_busy,
   input  logic                enable,
   input  aest_pkg::status_type st,
   output aest_pkg::cmd_type   cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready
);
   import aest_pkg::*;
   state_type state_ff, state_in;
   logic      out_ff, out_in;
   logic      acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in   = state_ff;
      out_in     = out_ff && !rsp_tready;
      cmd        = '0;
      req_tready = 1'b0;
      acc        = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_tready = 1'b1;
            acc = req_tvalid;
            if (acc && in_cmd) cmd.reply = 1'b1;
            else if (acc && enable) begin
               cmd.acc_en = 1'b1;
               if (in_last) begin
                  if (in_busy) cmd.busy_drop = 1'b1;
                  else begin
                     cmd.start_div = 1'b1;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: if (st.div_done) begin
            cmd.start_sqrt = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: if (st.sqrt_done) state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: if (st.mix_done) state_in = ST_UPD;
         ST_UPD: if (!out_ff) begin
            cmd.update = 1'b1;
            out_in = 1'b1;
            state_in = ST_ACC;
         end
         default: state_in = ST_ACC;
      endcase
   end
endmodule

FILE: src/aest_dp.sv
`timescale 1ns / 1ps
module aest_dp #(
   parameter int MAX_CHUNK = aest_pkg::MAX_CHUNK_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  aest_pkg::cmd_type   cmd,
   output aest_pkg::status_type st,
   input  logic signed [15:0]  in_sample,
   input  logic [31:0]         in_now,
   input  logic [2:0]          sens,
   input  logic [15:0]         min_rms,
   input  logic [7:0]          hold,
   input  logic [15:0]         cool,
   output logic [15:0]         out_rms,
   output logic [15:0]         out_floor,
   output logic [7:0]          out_hits,
   output logic                out_trig
);
   import aest_pkg::*;
   localparam int USED_MAX = (MAX_CHUNK + 1) / 2;
   localparam int CW = $clog2(USED_MAX + 1);
   localparam int SW = 32 + CW;

   logic          even_ff, even_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   noise_ff, noise_in;
   logic [7:0]    hit_ff, hit_in;
   logic [31:0]   reply_ff, reply_in;
   logic [31:0]   now_ff;
   logic [15:0]   mag;
   logic [31:0]   sq;
   logic          add_ok;

   // restoring divider, one quotient bit a cycle
   logic [SW-1:0] q_ff;
   logic [CW:0]   rem_ff;
   logic [CW-1:0] den_ff;
   logic [6:0]    dstep_ff;
   logic          dbusy_ff;
   logic [CW:0]   rtry;
   // square root, two bits a cycle
   logic [31:0]   sv_ff, sr_ff, sb_ff;
   logic          sbusy_ff;
   logic [15:0]   rms_ff;
   logic [37:0]   lhs_hit, rhs_hit, lhs_upd, rhs_upd;
   logic          hit_ff2, upd_ff;
   logic [41:0]   nmix_ff;
   // floor mix over 1000: reciprocal estimate, low-bit remainder, fix-up
   logic [64:0]   qprod;
   logic [31:0]   qe_ff, nq_ff;
   logic [11:0]   mrem_ff, mlow;
   logic [1:0]    mstep_ff, mfix;
   logic          mbusy_ff;
   logic [7:0]    hnew;

   assign mag    = in_sample[15] ? 16'(-in_sample) : in_sample;
   assign sq     = mag * mag;
   assign add_ok = even_ff && (32'(cnt_ff) < 32'(USED_MAX));
   assign rtry   = {rem_ff[CW-1:0], q_ff[SW-1]};

   always_comb begin
      even_in  = even_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      reply_in = cmd.reply ? in_now : reply_ff;
      if (cmd.acc_en) begin
         if (add_ok) begin
            sum_in = sum_ff + SW'(sq);
            cnt_in = cnt_ff + 1'b1;
         end
         even_in = !even_ff;
      end
      if (cmd.busy_drop || cmd.start_div) begin
         even_in = 1'b1;
         sum_in  = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         even_ff  <= 1'b1;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         reply_ff <= '0;
         dbusy_ff <= 1'b0;
         sbusy_ff <= 1'b0;
      end else begin
         even_ff  <= even_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         reply_ff <= reply_in;
         if (cmd.start_div) begin
            q_ff     <= add_ok ? sum_ff + SW'(sq) : sum_ff;
            den_ff   <= add_ok ? cnt_ff + 1'b1 : cnt_ff;
            rem_ff   <= '0;
            dstep_ff <= 7'(SW);
            dbusy_ff <= 1'b1;
            now_ff   <= in_now;
         end else if (dbusy_ff) begin
            if (rtry >= {1'b0, den_ff}) begin
               rem_ff <= rtry - {1'b0, den_ff};
               q_ff   <= {q_ff[SW-2:0], 1'b1};
            end else begin
               rem_ff <= rtry;
               q_ff   <= {q_ff[SW-2:0], 1'b0};
            end
            dstep_ff <= dstep_ff - 1'b1;
            if (dstep_ff == 7'd1) dbusy_ff <= 1'b0;
         end
         if (cmd.start_sqrt) begin
            // quotient fits 32 bits (at most 2^30)
            sv_ff    <= (den_ff == '0) ? 32'd0 : q_ff[31:0];
            sr_ff    <= '0;
            sb_ff    <= 32'h4000_0000;
            sbusy_ff <= 1'b1;
         end else if (sbusy_ff) begin
            if (sv_ff >= sr_ff + sb_ff) begin
               sv_ff <= sv_ff - (sr_ff + sb_ff);
               sr_ff <= (sr_ff >> 1) + sb_ff;
            end else sr_ff <= sr_ff >> 1;
            sb_ff <= sb_ff >> 2;
            if (sb_ff == 32'd1) sbusy_ff <= 1'b0;
         end
      end
   end

   // quotient complete once the last step has been written
   assign st.div_done  = !dbusy_ff;
   assign st.sqrt_done = sbusy_ff && sb_ff == 32'd1;
   assign st.mix_done  = mbusy_ff && mstep_ff == 2'd2;

   assign lhs_hit = 38'(sr_ff[15:0]) * 38'd655360;
   assign rhs_hit = 38'(noise_ff) * 38'(mult_tenths(sens));
   assign lhs_upd = 38'(sr_ff[15:0]) * 38'd327680;
   assign rhs_upd = 38'(noise_ff) * 38'd6;

   assign qprod = 65'(nmix_ff[41:10]) * 65'(RECIP_1000);
   // true remainder stays below 3000, so twelve low bits hold it
   assign mlow  = qe_ff[11:0] * 12'd1000;
   assign mfix  = {1'b0, mrem_ff >= 12'd1000} + {1'b0, mrem_ff >= 12'd2000};

   always_comb begin
      hnew = hit_ff;
      if (hit_ff2) begin
         if (hit_ff != 8'd255) hnew = hit_ff + 1'b1;
      end else if (hit_ff != 8'd0) hnew = hit_ff - 1'b1;
   end

   always_comb begin
      noise_in = noise_ff;
      hit_in   = hit_ff;
      if (cmd.busy_drop) hit_in = '0;
      if (cmd.update) begin
         if (upd_ff) noise_in = nq_ff;
         hit_in = (hnew >= hold && (now_ff - reply_ff) >= 32'(cool)) ? 8'd0 : hnew;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= NOISE_RESET;
         hit_ff   <= '0;
         mbusy_ff <= 1'b0;
      end else begin
         noise_ff <= noise_in;
         hit_ff   <= hit_in;
         if (cmd.eval) begin
            mbusy_ff <= 1'b1;
            mstep_ff <= '0;
         end else if (mbusy_ff) begin
            mstep_ff <= mstep_ff + 1'b1;
            if (mstep_ff == 2'd0) qe_ff <= qprod[63:32];
            if (mstep_ff == 2'd1) mrem_ff <= nmix_ff[11:0] - mlow;
            if (mstep_ff == 2'd2) begin
               nq_ff    <= qe_ff + 32'(mfix);
               mbusy_ff <= 1'b0;
            end
         end
      end
      if (cmd.eval) begin
         rms_ff  <= sr_ff[15:0];
         hit_ff2 <= (lhs_hit > rhs_hit) && (sr_ff[15:0] > min_rms);
         upd_ff  <= lhs_upd < rhs_upd;
         nmix_ff <= 42'(noise_ff) * 42'd985 + 42'(sr_ff[15:0]) * 42'd983040 + 42'd500;
      end
      if (cmd.update) begin
         out_rms   <= rms_ff;
         out_floor <= noise_in[31:16];
         out_hits  <= hit_in;
         out_trig  <= hnew >= hold && (now_ff - reply_ff) >= 32'(cool);
      end
   end
endmodule

FILE: src/adaptive_energy_sound_trigger.sv
`timescale 1ns / 1ps
// adaptive energy sound trigger
// req channel: one word per audio sample or reply event (cmd=1 records now_ms
// as reply time). tlast marks the final sample of a chunk; tuser carries
// playback busy, read on that sample.
// rsp channel: one word per finished chunk when enabled and not busy, with
// rms, noise floor, hit count and trigger.
// samples are accepted one per cycle while accumulating. after the last sample
// of a chunk req_tready stays low through the divider by the count of summed
// samples (one quotient bit a cycle over 42 bits with the default chunk size),
// the square root, evaluation, the floor update and the load of the result,
// which then shows on rsp.
// if rsp is stalled the result holds; a later chunk end waits in its final
// step until the held word is taken, so no result is lost.
// csr writes set the five registers; they are accepted every cycle.
// reset (synchronous, active high) restores register defaults, floor 400.0,
// clears the accumulators, hit count and reply time.
module adaptive_energy_sound_trigger #(
   parameter int MAX_CHUNK = aest_pkg::MAX_CHUNK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // cmd, sample[15:0], now_ms[31:0], pad
   input  logic        req_tlast,
   input  logic        req_tuser,  // playback_busy
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // rms[15:0], noise_floor[15:0], hits[7:0], trigger, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import aest_pkg::*;
   cmd_type    cmd;
   status_type st;
   logic        en_ff;
   logic [2:0]  sens_ff;
   logic [15:0] minr_ff, cool_ff, rms, floor_v;
   logic [7:0]  hold_ff, hits;
   logic        trig;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b1;
         sens_ff <= 3'd3;
         minr_ff <= 16'd1200;
         hold_ff <= 8'd3;
         cool_ff <= 16'd1200;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE: en_ff   <= csr_data[0];
            REG_SENS:   sens_ff <= csr_data[2:0];
            REG_MINRMS: minr_ff <= csr_data;
            REG_HOLD:   hold_ff <= csr_data[7:0];
            REG_COOL:   cool_ff <= csr_data;
            default: ;
         endcase
      end
   end

   aest_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .in_cmd(req_tdata[0]), .in_last(req_tlast), .in_busy(req_tuser),
      .enable(en_ff), .st, .cmd, .rsp_tvalid, .rsp_tready
   );

   aest_dp #(.MAX_CHUNK(MAX_CHUNK)) u_dp (
      .clock, .reset, .cmd, .st,
      .in_sample(req_tdata[16:1]), .in_now(req_tdata[48:17]),
      .sens(sens_ff), .min_rms(minr_ff), .hold(hold_ff), .cool(cool_ff),
      .out_rms(rms), .out_floor(floor_v), .out_hits(hits), .out_trig(trig)
   );

   assign rsp_tdata = {7'd0, trig, hits, floor_v, rms};
endmodule

FILE: src/aest_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aest_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [47:0] rsp_tdata
);
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AST_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `AST_IMPLY(a_trig_clears, clock, reset, rsp_tvalid && rsp_tdata[40], rsp_tdata[39:32] == 8'd0)
   `AST_NEXT(a_one_rsp, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)
endmodule

bind adaptive_energy_sound_trigger aest_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
